@@ sv/address_breakpoint_unit_defines.svh @@
// Assertion helpers for the files that check their own behavior.
`ifndef ADDRESS_BREAKPOINT_UNIT_DEFINES_SVH
`define ADDRESS_BREAKPOINT_UNIT_DEFINES_SVH

// A property that is checked only while reset is low.
`define ABU_ASSERT_RUN(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) expr) else $error(msg);

// A property that is checked on every edge, reset included.
`define ABU_ASSERT_ALL(name, expr, msg) \
   name: assert property (@(posedge clock) expr) else $error(msg);

`endif

@@ sv/abu_pkg.sv @@
`timescale 1ns / 1ps

package abu_pkg;

   localparam int ACTION_W          = 3;
   localparam int ADDRESS_W         = 16;
   localparam int TOTAL_W           = 17;
   localparam int ADDR_BITS_DEFAULT = 16;

   // Each map row holds 2**ROW_SEL_BITS breakpoint bits.
   localparam int ROW_SEL_BITS      = 5;

   typedef logic [ACTION_W-1:0]  action_type;
   typedef logic [ADDRESS_W-1:0] address_type;
   typedef logic [TOTAL_W-1:0]   total_type;

   localparam action_type ACT_ADD      = 3'd0;
   localparam action_type ACT_REMOVE   = 3'd1;
   localparam action_type ACT_SUPPRESS = 3'd2;
   localparam action_type ACT_CHECK    = 3'd3;
   localparam action_type ACT_STEP     = 3'd4;
   localparam action_type ACT_RETIRE   = 3'd5;
   localparam action_type ACT_CLEAR    = 3'd6;

endpackage

@@ sv/abu_req_if.sv @@
`timescale 1ns / 1ps

interface abu_req_if;
   import abu_pkg::*;

   logic        valid;
   logic        ready;
   action_type  action;
   address_type address;

   modport source (output valid, output action, output address, input ready);
   modport sink (input valid, input action, input address, output ready);
endinterface

@@ sv/abu_rsp_if.sv @@
`timescale 1ns / 1ps

interface abu_rsp_if;
   import abu_pkg::*;

   logic      valid;
   logic      ready;
   logic      pause;
   logic      debug_active;
   total_type breakpoint_total;

   modport source (output valid, output pause, output debug_active,
                   output breakpoint_total, input ready);
   modport sink (input valid, input pause, input debug_active,
                 input breakpoint_total, output ready);
endinterface

@@ sv/abu_map_ram.sv @@
`timescale 1ns / 1ps

module abu_map_ram #(
   parameter int ROW_AW = 11,
   parameter int ROW_W  = 32
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ROW_AW-1:0] rd_row,
   output logic [ROW_W-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ROW_AW-1:0] wr_row,
   input  logic [ROW_W-1:0]  wr_data
);

   logic [ROW_W-1:0] mem [2**ROW_AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_row];
      end
   end

endmodule

@@ sv/abu_ctrl.sv @@
`timescale 1ns / 1ps

module abu_ctrl #(
   parameter int ADDR_BITS = abu_pkg::ADDR_BITS_DEFAULT,
   parameter int ROW_AW    = ADDR_BITS - abu_pkg::ROW_SEL_BITS,
   parameter int ROW_W     = 2**abu_pkg::ROW_SEL_BITS
) (
   input  logic              clock,
   input  logic              reset,
   abu_req_if.sink           req_port,
   abu_rsp_if.source         rsp_port,
   output logic              ram_rd_en,
   output logic [ROW_AW-1:0] ram_rd_row,
   input  logic [ROW_W-1:0]  ram_rd_data,
   output logic              ram_wr_en,
   output logic [ROW_AW-1:0] ram_wr_row,
   output logic [ROW_W-1:0]  ram_wr_data
);
   import abu_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   localparam logic [ADDR_BITS:0] MapDepth = {1'b1, {ADDR_BITS{1'b0}}};

   logic [1:0]           state_ff, state_in;
   logic [ROW_AW-1:0]    clr_row_ff, clr_row_in;
   action_type           action_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS:0]   set_count_ff, set_count_in;
   logic [ADDR_BITS-1:0] skip_addr_ff, skip_addr_in;
   logic                 skip_armed_ff, skip_armed_in;
   logic                 step_wait_ff, step_wait_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pause_ff;
   logic                 rsp_active_ff;
   total_type            rsp_total_ff;

   logic [ADDR_BITS-1:0]    req_addr;
   logic                    accept;
   logic                    out_free;
   logic                    commit;
   logic [ROW_SEL_BITS-1:0] bit_sel;
   logic [ROW_W-1:0]        bit_mask;
   logic                    hit;
   logic                    skip_match;
   logic                    pause;
   logic                    exec_wr_en;
   logic [ROW_W-1:0]        exec_wr_data;

   assign req_addr = ADDR_BITS'(req_port.address);
   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept = req_port.valid && req_port.ready;

   // The result register frees up in the same cycle that its item is taken.
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign commit = (state_ff == ST_EXEC) && out_free;

   assign ram_rd_en  = accept;
   assign ram_rd_row = req_addr[ADDR_BITS-1:ROW_SEL_BITS];

   assign bit_sel    = addr_ff[ROW_SEL_BITS-1:0];
   assign bit_mask   = ROW_W'(1) << bit_sel;
   assign hit        = ram_rd_data[bit_sel];
   assign skip_match = (skip_addr_ff == addr_ff);

   always_comb begin
      set_count_in  = set_count_ff;
      skip_addr_in  = skip_addr_ff;
      skip_armed_in = skip_armed_ff;
      step_wait_in  = step_wait_ff;
      pause         = 1'b0;
      exec_wr_en    = 1'b0;
      exec_wr_data  = ram_rd_data;
      case (action_ff)
         ACT_ADD: begin
            if (!hit) begin
               exec_wr_en   = 1'b1;
               exec_wr_data = ram_rd_data | bit_mask;
               if (set_count_ff != MapDepth) begin
                  set_count_in = set_count_ff + 1'b1;
               end
            end
         end
         ACT_REMOVE: begin
            if (hit) begin
               exec_wr_en   = 1'b1;
               exec_wr_data = ram_rd_data & ~bit_mask;
               if (set_count_ff != '0) begin
                  set_count_in = set_count_ff - 1'b1;
               end
               if (skip_armed_ff && skip_match) begin
                  skip_armed_in = 1'b0;
               end
            end
         end
         ACT_SUPPRESS: begin
            if (hit) begin
               skip_addr_in  = addr_ff;
               skip_armed_in = 1'b1;
            end
         end
         ACT_CHECK: begin
            // A pending step holds off checking; an armed suppression is
            // used up by any check that runs and lets only its own address pass.
            if (!step_wait_ff) begin
               skip_armed_in = 1'b0;
               if (!(skip_armed_ff && skip_match) && hit) begin
                  skip_addr_in  = addr_ff;
                  skip_armed_in = 1'b1;
                  pause         = 1'b1;
               end
            end
         end
         ACT_STEP: begin
            step_wait_in = 1'b1;
         end
         ACT_RETIRE: begin
            if (step_wait_ff) begin
               step_wait_in = 1'b0;
               pause        = 1'b1;
            end
         end
         ACT_CLEAR: begin
            set_count_in  = '0;
            skip_armed_in = 1'b0;
            step_wait_in  = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      clr_row_in  = clr_row_ff;
      ram_wr_en   = 1'b0;
      ram_wr_row  = addr_ff[ADDR_BITS-1:ROW_SEL_BITS];
      ram_wr_data = exec_wr_data;
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_row  = clr_row_ff;
            ram_wr_data = '0;
            clr_row_in  = clr_row_ff + 1'b1;
            if (&clr_row_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               ram_wr_en = exec_wr_en;
               state_in  = (action_ff == ACT_CLEAR) ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_row_ff    <= '0;
         set_count_ff  <= '0;
         skip_addr_ff  <= '0;
         skip_armed_ff <= 1'b0;
         step_wait_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            set_count_ff  <= set_count_in;
            skip_addr_ff  <= skip_addr_in;
            skip_armed_ff <= skip_armed_in;
            step_wait_ff  <= step_wait_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_port.action;
         addr_ff   <= req_addr;
      end
      if (commit) begin
         rsp_pause_ff  <= pause;
         rsp_active_ff <= (set_count_in != '0) || skip_armed_in || step_wait_in;
         rsp_total_ff  <= TOTAL_W'(set_count_in);
      end
   end

   assign rsp_port.valid            = rsp_valid_ff;
   assign rsp_port.pause            = rsp_pause_ff;
   assign rsp_port.debug_active     = rsp_active_ff;
   assign rsp_port.breakpoint_total = rsp_total_ff;

endmodule

@@ sv/address_breakpoint_unit.sv @@
`timescale 1ns / 1ps
// Breakpoint unit for a CPU core's debug logic.
// req_port carries one item per action: an action code (add, remove,
// suppress at pc, check pc, step request, instruction retired, clear all)
// and an address. rsp_port returns exactly one item per request with pause,
// debug_active and the number of breakpoints set after the action.
// The breakpoint bits live in a RAM with one read and one write port, in rows
// of 32 bits; each request reads its row, and once the output register is
// free the unit modifies it, writes it back and loads the result register.
// A new item is taken only after the last one has loaded the result
// register, as set by that read-then-write pass over the map RAM.
// After reset, and after a clear-all item, the unit sweeps the RAM one row a
// cycle, 2**(ADDR_BITS-5) rows (2048 at 16 address bits), with req ready
// low; a clear-all result is still delivered while the sweep runs.
// A new request is taken while the previous result waits in the output
// register. If the receiver stalls, the next item waits with its row read
// until the output register frees, and no later request is taken meanwhile.
`include "address_breakpoint_unit_defines.svh"

module address_breakpoint_unit #(
   parameter int ADDR_BITS = abu_pkg::ADDR_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   abu_req_if.sink   req_port,
   abu_rsp_if.source rsp_port
);
   import abu_pkg::*;

   localparam int RowAw = ADDR_BITS - ROW_SEL_BITS;
   localparam int RowW  = 2**ROW_SEL_BITS;

   logic             ram_rd_en;
   logic [RowAw-1:0] ram_rd_row;
   logic [RowW-1:0]  ram_rd_data;
   logic             ram_wr_en;
   logic [RowAw-1:0] ram_wr_row;
   logic [RowW-1:0]  ram_wr_data;

   abu_ctrl #(
      .ADDR_BITS (ADDR_BITS),
      .ROW_AW    (RowAw),
      .ROW_W     (RowW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .rsp_port    (rsp_port),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_row  (ram_rd_row),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_row  (ram_wr_row),
      .ram_wr_data (ram_wr_data)
   );

   abu_map_ram #(
      .ROW_AW (RowAw),
      .ROW_W  (RowW)
   ) u_map_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_row  (ram_rd_row),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_row  (ram_wr_row),
      .wr_data (ram_wr_data)
   );

   `ABU_ASSERT_ALL(a_sweep_after_reset, reset |=> !req_port.ready, "request taken during clear sweep")
   `ABU_ASSERT_RUN(a_one_at_a_time, (req_port.valid && req_port.ready) |=> !req_port.ready, "second request taken while one is in flight")
   `ABU_ASSERT_RUN(a_active_with_total, (rsp_port.valid && rsp_port.breakpoint_total != '0) |-> rsp_port.debug_active, "breakpoints set but debug_active low")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import abu_pkg::*;

   localparam action_type ACT_UNUSED = 3'd7;
   localparam total_type  MAP_DEPTH  = 17'h10000;
   localparam int         HOT_COUNT  = 12;
   localparam int         MAX_PRINTS = 60;

   typedef struct packed {
      logic      pause;
      logic      debug_active;
      total_type breakpoint_total;
   } bp_status_type;

   logic clock;
   logic reset;

   abu_req_if req_bus ();
   abu_rsp_if rsp_bus ();

   address_breakpoint_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Shadow copy of the breakpoint state; only set addresses are stored.
   bit          bp_set [address_type];
   total_type   bp_total;
   address_type skip_pc;
   bit          skip_on;
   bit          step_on;

   bp_status_type status_queue [$];
   address_type   hot_pc [HOT_COUNT];

   bit source_gaps;
   bit sink_stalls;
   int err_count;
   int items_sent;
   int results_seen;
   int pauses_seen;
   int clears_sent;

   always #10 clock = ~clock;

   task automatic report_error(string msg);
      if (err_count < MAX_PRINTS)
         $display("[%0t] ERROR: %s", $time, msg);
      err_count++;
   endtask

   function automatic bp_status_type apply_action(action_type act, address_type pc);
      bp_status_type st;
      logic          stop;
      stop = 1'b0;
      case (act)
         ACT_ADD: begin
            if (!bp_set.exists(pc)) begin
               bp_set[pc] = 1'b1;
               if (bp_total < MAP_DEPTH)
                  bp_total++;
            end
         end
         ACT_REMOVE: begin
            if (bp_set.exists(pc)) begin
               bp_set.delete(pc);
               if (bp_total > 0)
                  bp_total--;
               if (skip_on && skip_pc == pc)
                  skip_on = 1'b0;
            end
         end
         ACT_SUPPRESS: begin
            if (bp_set.exists(pc)) begin
               skip_pc = pc;
               skip_on = 1'b1;
            end
         end
         ACT_CHECK: begin
            // A pending step blocks the check entirely.
            if (!step_on) begin
               if (skip_on && skip_pc == pc) begin
                  skip_on = 1'b0;
               end else begin
                  skip_on = 1'b0;
                  if (bp_set.exists(pc)) begin
                     skip_pc = pc;
                     skip_on = 1'b1;
                     stop    = 1'b1;
                  end
               end
            end
         end
         ACT_STEP: step_on = 1'b1;
         ACT_RETIRE: begin
            if (step_on) begin
               step_on = 1'b0;
               stop    = 1'b1;
            end
         end
         ACT_CLEAR: begin
            bp_set.delete();
            bp_total = '0;
            skip_on  = 1'b0;
            step_on  = 1'b0;
         end
         default: ;
      endcase
      st.pause            = stop;
      st.debug_active     = (bp_total != 0) || skip_on || step_on;
      st.breakpoint_total = bp_total;
      return st;
   endfunction

   task automatic send_item(action_type act, address_type pc);
      if (source_gaps && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.address <= pc;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      status_queue.push_back(apply_action(act, pc));
      items_sent++;
      if (act == ACT_CLEAR)
         clears_sent++;
   endtask

   // Receiver side: random stall bursts while enabled.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      bp_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.pause === 1'b1)
            pauses_seen++;
         if (status_queue.size() == 0) begin
            report_error("result arrived with nothing expected");
         end else begin
            want = status_queue.pop_front();
            if (rsp_bus.pause !== want.pause)
               report_error($sformatf("pause: expected %0b, got %0b",
                                      want.pause, rsp_bus.pause));
            if (rsp_bus.debug_active !== want.debug_active)
               report_error($sformatf("debug_active: expected %0b, got %0b",
                                      want.debug_active, rsp_bus.debug_active));
            if (rsp_bus.breakpoint_total !== want.breakpoint_total)
               report_error($sformatf("breakpoint_total: expected %0d, got %0d",
                                      want.breakpoint_total, rsp_bus.breakpoint_total));
         end
      end
   end

   task automatic test_map_updates();
      send_item(ACT_ADD, 16'h0000);
      send_item(ACT_ADD, 16'hFFFF);
      send_item(ACT_ADD, 16'hFFFF);
      send_item(ACT_REMOVE, 16'h1234);
      send_item(ACT_REMOVE, 16'hFFFF);
      send_item(ACT_REMOVE, 16'hFFFF);
      send_item(ACT_ADD, 16'hFFFF);
   endtask

   task automatic test_suppression();
      // Suppressing where no breakpoint is set must not arm anything.
      send_item(ACT_SUPPRESS, 16'h5555);
      send_item(ACT_CHECK, 16'h0000);
      send_item(ACT_CHECK, 16'h0000);
      send_item(ACT_CHECK, 16'h0000);
      send_item(ACT_SUPPRESS, 16'hFFFF);
      send_item(ACT_CHECK, 16'h0000);
      send_item(ACT_SUPPRESS, 16'hFFFF);
      send_item(ACT_REMOVE, 16'hFFFF);
      send_item(ACT_CHECK, 16'hAAAA);
   endtask

   task automatic test_single_step();
      send_item(ACT_RETIRE, 16'h0000);
      send_item(ACT_STEP, 16'h0000);
      send_item(ACT_STEP, 16'hFFFF);
      send_item(ACT_CHECK, 16'h0000);
      send_item(ACT_RETIRE, 16'h0000);
      send_item(ACT_RETIRE, 16'h0000);
      send_item(ACT_UNUSED, 16'hFFFF);
   endtask

   task automatic test_clear_all();
      send_item(ACT_STEP, 16'h0000);
      send_item(ACT_CLEAR, 16'h0000);
      send_item(ACT_REMOVE, 16'h0000);
      send_item(ACT_CHECK, 16'h0000);
   endtask

   function automatic address_type pick_pc();
      if ($urandom_range(0, 99) < 85)
         return hot_pc[$urandom_range(0, HOT_COUNT - 1)];
      return address_type'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic action_type pick_action();
      int r;
      r = $urandom_range(0, 999);
      if (r < 7)   return ACT_CLEAR;
      if (r < 30)  return ACT_UNUSED;
      if (r < 330) return ACT_CHECK;
      if (r < 520) return ACT_ADD;
      if (r < 620) return ACT_REMOVE;
      if (r < 730) return ACT_SUPPRESS;
      if (r < 840) return ACT_STEP;
      return ACT_RETIRE;
   endfunction

   // Mostly debugger-like sequences with random addresses, plus loose items.
   // Idling is only re-rolled when the run is throttled.
   task automatic run_traffic(int count, bit throttled);
      address_type pc;
      int          done;
      done = 0;
      while (done < count) begin
         if (throttled && done % 64 == 0) begin
            source_gaps = $urandom_range(0, 2) != 0;
            sink_stalls = $urandom_range(0, 2) != 0;
         end
         pc = pick_pc();
         case ($urandom_range(0, 9))
            0, 1: begin
               send_item(ACT_ADD, pc);
               send_item(ACT_CHECK, pc);
               send_item(ACT_CHECK, pc);
               send_item(ACT_CHECK, pc);
               done += 4;
            end
            2: begin
               send_item(ACT_STEP, pc);
               send_item(ACT_CHECK, pc);
               send_item(ACT_RETIRE, pc);
               send_item(ACT_CHECK, pc);
               done += 4;
            end
            3: begin
               send_item(ACT_SUPPRESS, pc);
               send_item(ACT_CHECK, pc);
               send_item(ACT_CHECK, pc);
               done += 3;
            end
            default: begin
               send_item(pick_action(), pc);
               done += 1;
            end
         endcase
      end
   endtask

   task automatic test_random_traffic();
      hot_pc[0] = 16'h0000;
      hot_pc[1] = 16'hFFFF;
      for (int i = 2; i < HOT_COUNT; i++)
         hot_pc[i] = address_type'($urandom_range(0, 16'hFFFF));
      run_traffic(800, 1'b1);
   endtask

   task automatic test_unthrottled_tail();
      for (int i = 0; i < HOT_COUNT; i++)
         hot_pc[i] = address_type'($urandom_range(0, 16'hFFFF));
      source_gaps = 1'b0;
      sink_stalls = 1'b0;
      run_traffic(320, 1'b0);
   endtask

   initial begin
      clock           = 1'b0;
      reset          <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.action  <= ACT_ADD;
      req_bus.address <= '0;
      bp_total        = '0;
      skip_pc         = '0;
      skip_on         = 1'b0;
      step_on         = 1'b0;
      source_gaps     = 1'b1;
      sink_stalls     = 1'b1;
      err_count       = 0;
      items_sent      = 0;
      results_seen    = 0;
      pauses_seen     = 0;
      clears_sent     = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_map_updates();
      test_suppression();
      test_single_step();
      test_clear_all();
      test_random_traffic();
      // The tail runs with idling switched off on both sides.
      source_gaps = 1'b0;
      sink_stalls = 1'b0;
      test_unthrottled_tail();

      req_bus.valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d items (%0d clear-all sweeps), checked %0d results, %0d with pause.",
               items_sent, clears_sent, results_seen, pauses_seen);
      if (err_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results still expected.", status_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/abu_pkg.sv
sv/abu_req_if.sv
sv/abu_rsp_if.sv
sv/abu_map_ram.sv
sv/abu_ctrl.sv
sv/address_breakpoint_unit.sv
tb/sv/tb_top.sv
